// File: sv/gqg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gqg_pkg;

	// Layout constants.
	localparam int TAB_COLUMNS = 8;
	localparam int COORD_BITS  = 16;

	// Pen width, the working width of the coordinate arithmetic, and the
	// widths of the tab spacing and of the remainder unit.
	localparam int PW        = COORD_BITS;
	localparam int XW        = ((PW > 16) ? PW : 16) + 3;
	localparam int SPW       = $clog2(255 * TAB_COLUMNS + 1);
	localparam int DIV_STEPS = PW;
	localparam int DCW       = $clog2(DIV_STEPS + 1);

	localparam longint PEN_MAX_L = (longint'(1) <<< (PW - 1)) - 1;
	localparam longint PEN_MIN_L = -PEN_MAX_L - 1;
	localparam logic signed [XW-1:0] PEN_MAX_X = XW'(PEN_MAX_L);
	localparam logic signed [XW-1:0] PEN_MIN_X = XW'(PEN_MIN_L);
	localparam logic signed [XW-1:0] S16_MAX_X = XW'(32767);
	localparam logic signed [XW-1:0] S16_MIN_X = XW'(-32768);

	// Character codes.
	localparam logic [7:0] CH_TAB     = 8'd9;
	localparam logic [7:0] CH_NEWLINE = 8'd10;
	localparam logic [7:0] CH_SPACE   = 8'd32;

	// Vertex order TL, BR, BL, TL, TR, BR: bit k tells whether vertex k
	// sits on the right edge, and whether it sits on the bottom edge.
	localparam int         VK_W       = 3;
	localparam logic [VK_W-1:0] VK_LAST = 3'd5;
	localparam logic [5:0] VTX_RIGHT  = 6'b110010;
	localparam logic [5:0] VTX_BOTTOM = 6'b100110;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_ORIGIN_X      = 2'd0,
		REG_ORIGIN_Y      = 2'd1,
		REG_LINE_HEIGHT   = 2'd2,
		REG_SPACE_ADVANCE = 2'd3
	} reg_index_t;

	// Class of the captured character.
	typedef enum logic [1:0] {
		CC_GLYPH   = 2'd0,
		CC_TAB     = 2'd1,
		CC_NEWLINE = 2'd2,
		CC_SPACE   = 2'd3
	} char_class_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic            load;
		logic            geom;
		logic            div_init;
		logic            div_step;
		logic            tab_done;
		logic            newline;
		logic            space;
		logic            emit;
		logic            pen_adv;
		logic [VK_W-1:0] vtx_k;
	} gqg_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		char_class_t cls;
		logic        spacing_zero;
	} gqg_sts_t;

	// Saturate a working value to the signed pen range.
	function automatic logic signed [PW-1:0] sat_pen(input logic signed [XW-1:0] v);
		logic signed [XW-1:0] r;
		r = v;
		if (v > PEN_MAX_X) r = PEN_MAX_X;
		if (v < PEN_MIN_X) r = PEN_MIN_X;
		return r[PW-1:0];
	endfunction

	// Saturate a working value to 16-bit signed.
	function automatic logic signed [15:0] sat16(input logic signed [XW-1:0] v);
		logic signed [XW-1:0] r;
		r = v;
		if (v > S16_MAX_X) r = S16_MAX_X;
		if (v < S16_MIN_X) r = S16_MIN_X;
		return r[15:0];
	endfunction

endpackage

`default_nettype wire

// File: sv/text_glyph_quad_generator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// A printable character passes through accept, decode and six vertex beats, one vertex per beat, and
// each vertex beat waits while the receiver has not yet taken the previous vertex.
// Space, newline and a tab at zero spacing pass through accept and decode only; any other tab
// also runs the one bit per cycle remainder unit for the tab stop, then a final pen step.
// Reset is asynchronous and active low: pen at the origin reset value, counter zero, registers
// at their reset values, no vertex pending.

module text_glyph_quad_generator_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [15:0]       cfg_wdata,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              start_text,
	input  wire logic [7:0]        char_code,
	input  wire logic [7:0]        glyph_width,
	input  wire logic [7:0]        glyph_height,
	input  wire logic signed [7:0] glyph_descent,
	input  wire logic [7:0]        glyph_advance,
	input  wire logic [15:0]       uv_left,
	input  wire logic [15:0]       uv_right,
	input  wire logic [15:0]       uv_top,
	input  wire logic [15:0]       uv_bottom,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic signed [15:0]     vert_x,
	output logic signed [15:0]     vert_y,
	output logic [15:0]            tex_u,
	output logic [15:0]            tex_v,
	output logic [15:0]            vertex_index,
	output logic                   last_of_quad
);
	import gqg_pkg::*;

	gqg_cmd_t cmd;
	gqg_sts_t sts;

	// Sequencer.
	gqg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Pen, geometry and vertex datapath.
	gqg_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.start_text    (start_text),
		.char_code     (char_code),
		.glyph_width   (glyph_width),
		.glyph_height  (glyph_height),
		.glyph_descent (glyph_descent),
		.glyph_advance (glyph_advance),
		.uv_left       (uv_left),
		.uv_right      (uv_right),
		.uv_top        (uv_top),
		.uv_bottom     (uv_bottom),
		.vert_x        (vert_x),
		.vert_y        (vert_y),
		.tex_u         (tex_u),
		.tex_v         (tex_v),
		.vertex_index  (vertex_index),
		.last_of_quad  (last_of_quad)
	);

endmodule

`default_nettype wire

// File: sv/gqg_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module gqg_datapath (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire gqg_pkg::gqg_cmd_t    cmd,
	output gqg_pkg::gqg_sts_t         sts,
	input  wire logic                 cfg_we,
	input  wire logic [1:0]           cfg_index,
	input  wire logic [15:0]          cfg_wdata,
	input  wire logic                 start_text,
	input  wire logic [7:0]           char_code,
	input  wire logic [7:0]           glyph_width,
	input  wire logic [7:0]           glyph_height,
	input  wire logic signed [7:0]    glyph_descent,
	input  wire logic [7:0]           glyph_advance,
	input  wire logic [15:0]          uv_left,
	input  wire logic [15:0]          uv_right,
	input  wire logic [15:0]          uv_top,
	input  wire logic [15:0]          uv_bottom,
	output logic signed [15:0]        vert_x,
	output logic signed [15:0]        vert_y,
	output logic [15:0]               tex_u,
	output logic [15:0]               tex_v,
	output logic [15:0]               vertex_index,
	output logic                      last_of_quad
);
	import gqg_pkg::*;

	// Configuration registers.
	logic signed [15:0] origin_x_q, origin_y_q;
	logic [7:0]         line_height_q, space_advance_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q      <= '0;
			origin_y_q      <= '0;
			line_height_q   <= 8'd16;
			space_advance_q <= 8'd8;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_ORIGIN_X:      origin_x_q      <= cfg_wdata;
				REG_ORIGIN_Y:      origin_y_q      <= cfg_wdata;
				REG_LINE_HEIGHT:   line_height_q   <= cfg_wdata[7:0];
				REG_SPACE_ADVANCE: space_advance_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// Captured character beat.
	logic [7:0]        ch_q, gw_q, gh_q, ga_q;
	logic signed [7:0] gd_q;
	logic [15:0]       ul_q, ur_q, vt_q, vb_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ch_q <= char_code;
			gw_q <= glyph_width;
			gh_q <= glyph_height;
			gd_q <= glyph_descent;
			ga_q <= glyph_advance;
			ul_q <= uv_left;
			ur_q <= uv_right;
			vt_q <= uv_top;
			vb_q <= uv_bottom;
		end
	end

	// Origin in pen range and tab spacing.
	logic signed [PW-1:0]  ox, oy;
	logic [SPW-1:0]        spacing;

	assign ox      = sat_pen(XW'(origin_x_q));
	assign oy      = sat_pen(XW'(origin_y_q));
	assign spacing = SPW'(space_advance_q * TAB_COLUMNS);

	// Character classification.
	always_comb begin
		case (ch_q)
			CH_TAB:     sts.cls = CC_TAB;
			CH_NEWLINE: sts.cls = CC_NEWLINE;
			CH_SPACE:   sts.cls = CC_SPACE;
			default:    sts.cls = CC_GLYPH;
		endcase
		sts.spacing_zero = (space_advance_q == 8'd0);
	end

	// Pen state and the working values derived from it.
	logic signed [PW-1:0] pen_x_q, pen_y_q;
	logic [15:0]          vcnt_q;
	logic signed [XW-1:0] px, py, col, r_x, t_y, b_y, nl_y, sp_x, tab_x;
	logic                 col_neg_q;
	logic [SPW-1:0]       rem_q;
	logic [DIV_STEPS-1:0] dvd_q;
	logic signed [PW-1:0] radv_q;

	assign px    = XW'(pen_x_q);
	assign py    = XW'(pen_y_q);
	assign col   = px - XW'(ox);
	assign r_x   = px + XW'($signed({1'b0, gw_q}));
	assign t_y   = py - XW'(gd_q);
	assign b_y   = t_y - XW'($signed({1'b0, gh_q}));
	assign nl_y  = py - XW'($signed({1'b0, line_height_q}));
	assign sp_x  = px + XW'($signed({1'b0, ga_q}));
	assign tab_x = col_neg_q
		? px + XW'($signed({1'b0, spacing})) + XW'($signed({1'b0, rem_q}))
		: px + XW'($signed({1'b0, spacing})) - XW'($signed({1'b0, rem_q}));

	// Restoring remainder step: one dividend bit per cycle.
	logic [SPW:0]   trial;
	logic [SPW-1:0] rem_n;
	logic signed [XW-1:0] col_abs;

	assign col_abs = col[XW-1] ? -col : col;
	assign trial   = {rem_q, dvd_q[DIV_STEPS-1]};
	assign rem_n   = (trial >= {1'b0, spacing}) ? SPW'(trial - {1'b0, spacing})
	                                            : trial[SPW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			dvd_q     <= col_abs[DIV_STEPS-1:0];
			rem_q     <= '0;
			col_neg_q <= col[XW-1];
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[DIV_STEPS-2:0], 1'b0};
			rem_q <= rem_n;
		end
	end

	// Quad corners, saturated once per glyph.
	logic signed [15:0] l16_q, r16_q, t16_q, b16_q;

	always_ff @(posedge clk) begin
		if (cmd.geom) begin
			l16_q  <= sat16(px);
			r16_q  <= sat16(r_x);
			t16_q  <= sat16(t_y);
			b16_q  <= sat16(b_y);
			radv_q <= sat_pen(r_x);
		end
	end

	// Pen and vertex counter updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q <= '0;
			pen_y_q <= '0;
			vcnt_q  <= '0;
		end else begin
			if (cmd.load && start_text) begin
				pen_x_q <= ox;
				pen_y_q <= oy;
				vcnt_q  <= '0;
			end
			if (cmd.tab_done) pen_x_q <= sat_pen(tab_x);
			if (cmd.newline) begin
				pen_x_q <= ox;
				pen_y_q <= sat_pen(nl_y);
			end
			if (cmd.space)   pen_x_q <= sat_pen(sp_x);
			if (cmd.pen_adv) pen_x_q <= radv_q;
			if (cmd.emit && (vcnt_q != 16'hFFFF)) vcnt_q <= vcnt_q + 16'd1;
		end
	end

	// Output beat register.
	logic is_right, is_bottom;

	assign is_right  = VTX_RIGHT[cmd.vtx_k];
	assign is_bottom = VTX_BOTTOM[cmd.vtx_k];

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			vert_x       <= is_right  ? r16_q : l16_q;
			vert_y       <= is_bottom ? b16_q : t16_q;
			tex_u        <= is_right  ? ur_q  : ul_q;
			tex_v        <= is_bottom ? vb_q  : vt_q;
			vertex_index <= vcnt_q;
			last_of_quad <= (cmd.vtx_k == VK_LAST);
		end
	end

endmodule

`default_nettype wire

// File: sv/gqg_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module gqg_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire gqg_pkg::gqg_sts_t sts,
	output gqg_pkg::gqg_cmd_t      cmd
);
	import gqg_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_DECODE = 5'b00010,
		ST_DIV    = 5'b00100,
		ST_TAB    = 5'b01000,
		ST_EMIT   = 5'b10000
	} state_t;

	state_t          state_q, state_n;
	logic [VK_W-1:0] vtx_k_q, vtx_k_n;
	logic [DCW-1:0]  div_cnt_q, div_cnt_n;
	logic            out_valid_q, out_valid_n;
	logic            emit_ok;

	assign emit_ok   = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// Sequencing of one character.
	always_comb begin
		state_n   = state_q;
		vtx_k_n   = vtx_k_q;
		div_cnt_n = div_cnt_q;
		cmd       = '0;
		cmd.vtx_k = vtx_k_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_n  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (sts.cls)
					CC_TAB: begin
						if (sts.spacing_zero) begin
							state_n = ST_IDLE;
						end else begin
							cmd.div_init = 1'b1;
							div_cnt_n    = DCW'(DIV_STEPS);
							state_n      = ST_DIV;
						end
					end
					CC_NEWLINE: begin
						cmd.newline = 1'b1;
						state_n     = ST_IDLE;
					end
					CC_SPACE: begin
						cmd.space = 1'b1;
						state_n   = ST_IDLE;
					end
					default: begin
						cmd.geom = 1'b1;
						vtx_k_n  = '0;
						state_n  = ST_EMIT;
					end
				endcase
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				div_cnt_n    = div_cnt_q - DCW'(1);
				if (div_cnt_q == DCW'(1)) state_n = ST_TAB;
			end
			ST_TAB: begin
				cmd.tab_done = 1'b1;
				state_n      = ST_IDLE;
			end
			ST_EMIT: begin
				if (emit_ok) begin
					cmd.emit = 1'b1;
					if (vtx_k_q == VK_LAST) begin
						cmd.pen_adv = 1'b1;
						vtx_k_n     = '0;
						state_n     = ST_IDLE;
					end else begin
						vtx_k_n = vtx_k_q + VK_W'(1);
					end
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// Output beat valid flag.
	always_comb begin
		out_valid_n = out_valid_q;
		if (out_ready) out_valid_n = 1'b0;
		if (cmd.emit)  out_valid_n = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			vtx_k_q     <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_n;
			vtx_k_q     <= vtx_k_n;
			div_cnt_q   <= div_cnt_n;
			out_valid_q <= out_valid_n;
		end
	end

	// The vertex counter only moves inside a quad.
	a_vtx_k_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_EMIT) |-> (vtx_k_q == '0))
		else $error("vertex slot nonzero outside emission");

	// The remainder unit is drained before a new character is taken.
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (div_cnt_q == '0))
		else $error("remainder steps pending while ready");

	// The sixth vertex ends the character.
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && (vtx_k_q == VK_LAST)) |=> (state_q == ST_IDLE))
		else $error("controller did not return to idle after a quad");

	// An emitted vertex is visible in the next cycle.
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid_q)
		else $error("emitted vertex not presented");

endmodule

`default_nettype wire

// File: verif/tb_text_glyph_quad_generator_unit.sv
`timescale 1ns / 1ps

module tb_text_glyph_quad_generator_unit;
	import gqg_pkg::*;

	localparam int  SETTLE_CYCLES = 32;
	localparam int  CYCLE_LIMIT   = 600000;
	localparam int  PRINT_CAP     = 40;
	localparam longint PEN_HI     = (longint'(1) << (COORD_BITS - 1)) - 1;
	localparam longint PEN_LO     = -PEN_HI - 1;

	// One character beat as offered to the block.
	typedef struct {
		logic              start;
		logic [7:0]        ch;
		logic [7:0]        w;
		logic [7:0]        h;
		logic signed [7:0] d;
		logic [7:0]        adv;
		logic [15:0]       ul;
		logic [15:0]       ur;
		logic [15:0]       vt;
		logic [15:0]       vb;
	} glyph_beat_t;

	// One vertex beat as expected from the block.
	typedef struct {
		logic signed [15:0] vx;
		logic signed [15:0] vy;
		logic [15:0]        u;
		logic [15:0]        v;
		logic [15:0]        idx;
		logic               last;
	} quad_vertex_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [1:0]        cfg_index;
	logic [15:0]       cfg_wdata;
	logic              in_valid;
	logic              in_ready;
	logic              start_text;
	logic [7:0]        char_code;
	logic [7:0]        glyph_width;
	logic [7:0]        glyph_height;
	logic signed [7:0] glyph_descent;
	logic [7:0]        glyph_advance;
	logic [15:0]       uv_left;
	logic [15:0]       uv_right;
	logic [15:0]       uv_top;
	logic [15:0]       uv_bottom;
	logic              out_valid;
	logic              out_ready;
	logic signed [15:0] vert_x;
	logic signed [15:0] vert_y;
	logic [15:0]       tex_u;
	logic [15:0]       tex_v;
	logic [15:0]       vertex_index;
	logic              last_of_quad;

	// Layout state mirrored from the block, at its reset values.
	logic signed [15:0] cfg_ox = 16'sd0;
	logic signed [15:0] cfg_oy = 16'sd0;
	logic [7:0]         cfg_lh = 8'd16;
	logic [7:0]         cfg_sa = 8'd8;
	longint             pen_x = 0;
	longint             pen_y = 0;
	int                 vtx_count = 0;

	quad_vertex_t pending_vertices[$];

	int  mismatches = 0;
	int  cycle_count = 0;
	int  vertices_seen = 0;
	int  glyphs_sent = 0;
	int  spaces_sent = 0;
	int  tabs_sent = 0;
	int  newlines_sent = 0;
	int  reg_phases = 0;
	bit  in_idle_on = 1'b1;
	bit  out_idle_on = 1'b1;
	int  hold_left = 0;
	int  rx_gap_left = 0;

	text_glyph_quad_generator_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.start_text   (start_text),
		.char_code    (char_code),
		.glyph_width  (glyph_width),
		.glyph_height (glyph_height),
		.glyph_descent(glyph_descent),
		.glyph_advance(glyph_advance),
		.uv_left      (uv_left),
		.uv_right     (uv_right),
		.uv_top       (uv_top),
		.uv_bottom    (uv_bottom),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.vert_x       (vert_x),
		.vert_y       (vert_y),
		.tex_u        (tex_u),
		.tex_v        (tex_v),
		.vertex_index (vertex_index),
		.last_of_quad (last_of_quad)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Cycle counter that ends a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout: run stopped after %0d cycles with %0d vertices outstanding",
				cycle_count, pending_vertices.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// Prints one mismatch line, up to a cap, and counts every one.
	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("MISMATCH at %0t: %s", $time, msg);
	endtask

	function automatic longint clamp_pen(input longint v);
		if (v > PEN_HI) return PEN_HI;
		if (v < PEN_LO) return PEN_LO;
		return v;
	endfunction

	function automatic logic signed [15:0] clip16(input longint v);
		if (v > 32767) return 16'sh7FFF;
		if (v < -32768) return 16'sh8000;
		return 16'(v);
	endfunction

	// Moves the pen for one accepted character and queues the quad vertices it causes.
	task automatic layout_char(input glyph_beat_t b);
		longint ox;
		longint spacing;
		longint col;
		longint l;
		longint r;
		longint t;
		longint bt;
		quad_vertex_t vtx;
		ox = clamp_pen(longint'(cfg_ox));
		if (b.start) begin
			pen_x = ox;
			pen_y = clamp_pen(longint'(cfg_oy));
			vtx_count = 0;
		end
		if (b.ch == CH_TAB) begin
			tabs_sent++;
			spacing = longint'(cfg_sa) * TAB_COLUMNS;
			if (spacing != 0) begin
				col = pen_x - ox;
				pen_x = clamp_pen(pen_x + (spacing - col % spacing));
			end
		end else if (b.ch == CH_NEWLINE) begin
			newlines_sent++;
			pen_y = clamp_pen(pen_y - longint'(cfg_lh));
			pen_x = ox;
		end else if (b.ch == CH_SPACE) begin
			spaces_sent++;
			pen_x = clamp_pen(pen_x + longint'(b.adv));
		end else begin
			glyphs_sent++;
			l = pen_x;
			r = pen_x + longint'(b.w);
			t = pen_y - longint'(b.d);
			bt = t - longint'(b.h);
			for (int k = 0; k < 6; k++) begin
				vtx.vx = clip16(VTX_RIGHT[k] ? r : l);
				vtx.vy = clip16(VTX_BOTTOM[k] ? bt : t);
				vtx.u = VTX_RIGHT[k] ? b.ur : b.ul;
				vtx.v = VTX_BOTTOM[k] ? b.vb : b.vt;
				vtx.idx = vtx_count[15:0];
				vtx.last = (k == 5);
				if (vtx_count < 65535)
					vtx_count++;
				pending_vertices.push_back(vtx);
			end
			pen_x = clamp_pen(r);
		end
	endtask

	// Offers one character beat, after a random gap while input gaps are on, and waits until it is taken.
	task automatic offer_char(input glyph_beat_t b);
		int gap;
		gap = in_idle_on ? $urandom_range(0, 13) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		start_text    <= b.start;
		char_code     <= b.ch;
		glyph_width   <= b.w;
		glyph_height  <= b.h;
		glyph_descent <= b.d;
		glyph_advance <= b.adv;
		uv_left       <= b.ul;
		uv_right      <= b.ur;
		uv_top        <= b.vt;
		uv_bottom     <= b.vb;
		do @(posedge clk); while (!in_ready);
		layout_char(b);
	endtask

	// Stops offering, waits for every queued vertex, then lets a tab finish.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_vertices.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_one(input reg_index_t idx, input logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_ORIGIN_X:      cfg_ox = val;
			REG_ORIGIN_Y:      cfg_oy = val;
			REG_LINE_HEIGHT:   cfg_lh = val[7:0];
			REG_SPACE_ADVANCE: cfg_sa = val[7:0];
			default: ;
		endcase
	endtask

	// Writes all four registers in a row; only legal while the block is idle.
	task automatic set_registers(input logic [15:0] ox, input logic [15:0] oy,
		input logic [15:0] lh, input logic [15:0] sa);
		write_one(REG_ORIGIN_X, ox);
		write_one(REG_ORIGIN_Y, oy);
		write_one(REG_LINE_HEIGHT, lh);
		write_one(REG_SPACE_ADVANCE, sa);
		cfg_we <= 1'b0;
		reg_phases++;
	endtask

	// Random metrics biased toward small glyphs so the pen rarely pins at the edge.
	function automatic glyph_beat_t rand_beat(input logic st, input logic [7:0] ch);
		glyph_beat_t b;
		b.start = st;
		b.ch = ch;
		b.w = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 24)) : 8'($urandom_range(0, 255));
		b.h = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 40)) : 8'($urandom_range(0, 255));
		b.d = 8'($urandom_range(0, 255));
		b.adv = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 16)) : 8'($urandom_range(0, 255));
		b.ul = 16'($urandom_range(0, 65535));
		b.ur = 16'($urandom_range(0, 65535));
		b.vt = 16'($urandom_range(0, 65535));
		b.vb = 16'($urandom_range(0, 65535));
		return b;
	endfunction

	// Plausible running text: mostly printable glyphs with spaces, tabs and line breaks.
	function automatic glyph_beat_t text_beat();
		int pick;
		logic [7:0] ch;
		pick = $urandom_range(0, 99);
		if (pick < 10)
			ch = CH_SPACE;
		else if (pick < 15)
			ch = CH_TAB;
		else if (pick < 20)
			ch = CH_NEWLINE;
		else
			ch = 8'($urandom_range(33, 126));
		return rand_beat($urandom_range(0, 19) == 0, ch);
	endfunction

	// Anything the fields allow.
	function automatic glyph_beat_t noise_beat();
		glyph_beat_t b;
		b = rand_beat($urandom_range(0, 1), 8'($urandom_range(0, 255)));
		b.w = 8'($urandom_range(0, 255));
		b.h = 8'($urandom_range(0, 255));
		b.adv = 8'($urandom_range(0, 255));
		return b;
	endfunction

	// Origin choice: either extreme, a spot near zero, or anywhere.
	function automatic logic [15:0] pick_origin();
		case ($urandom_range(0, 3))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'($urandom_range(0, 600) - 300);
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// Byte register choice, with junk in the unused upper byte.
	function automatic logic [15:0] pick_byte_reg();
		logic [7:0] upper;
		upper = 8'($urandom_range(0, 255));
		case ($urandom_range(0, 3))
			0: return {upper, 8'd0};
			1: return {upper, 8'd255};
			default: return {upper, 8'($urandom_range(1, 32))};
		endcase
	endfunction

	// Receiver: random gap before each vertex beat, plus a long hold when asked.
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (out_ready && out_valid) begin
				rx_gap_left = out_idle_on ? $urandom_range(0, 13) : 0;
				if (rx_gap_left > 0)
					out_ready <= 1'b0;
			end else if (!out_ready) begin
				if (rx_gap_left > 0)
					rx_gap_left--;
				if (rx_gap_left == 0)
					out_ready <= 1'b1;
			end
		end
	end

	// Each accepted vertex beat is compared with the oldest expected vertex.
	always @(posedge clk) begin : vertex_check
		quad_vertex_t want;
		if (arst_n && out_valid && out_ready) begin
			vertices_seen++;
			if (pending_vertices.size() == 0) begin
				note_mismatch($sformatf("vertex beat x=%0d y=%0d index=%0d with none expected",
					vert_x, vert_y, vertex_index));
			end else begin
				want = pending_vertices.pop_front();
				if (vert_x !== want.vx)
					note_mismatch($sformatf("index %0d: vert_x %0d, expected %0d",
						want.idx, vert_x, want.vx));
				if (vert_y !== want.vy)
					note_mismatch($sformatf("index %0d: vert_y %0d, expected %0d",
						want.idx, vert_y, want.vy));
				if (tex_u !== want.u)
					note_mismatch($sformatf("index %0d: tex_u %h, expected %h",
						want.idx, tex_u, want.u));
				if (tex_v !== want.v)
					note_mismatch($sformatf("index %0d: tex_v %h, expected %h",
						want.idx, tex_v, want.v));
				if (vertex_index !== want.idx)
					note_mismatch($sformatf("vertex_index %0d, expected %0d",
						vertex_index, want.idx));
				if (last_of_quad !== want.last)
					note_mismatch($sformatf("index %0d: last_of_quad %b, expected %b",
						want.idx, last_of_quad, want.last));
			end
		end
	end

	// Reset register values: field extremes, every character class, start on controls.
	task automatic test_reset_defaults();
		glyph_beat_t b;
		// Glyph before any start runs on the reset pen and counter.
		b = rand_beat(1'b0, "A");
		b.w = 8'd255; b.h = 8'd255; b.d = -8'sd128;
		b.ul = 16'h0000; b.ur = 16'hFFFF; b.vt = 16'hFFFF; b.vb = 16'h0000;
		offer_char(b);
		b = rand_beat(1'b0, 8'h00);
		b.w = 8'd0; b.h = 8'd0; b.d = 8'sd127;
		b.ul = 16'hFFFF; b.ur = 16'h0000; b.vt = 16'h0000; b.vb = 16'hFFFF;
		offer_char(b);
		b = rand_beat(1'b0, CH_SPACE);
		b.adv = 8'd255;
		offer_char(b);
		b = rand_beat(1'b0, CH_SPACE);
		b.adv = 8'd0;
		offer_char(b);
		offer_char(rand_beat(1'b0, CH_TAB));
		offer_char(rand_beat(1'b0, CH_TAB));
		offer_char(rand_beat(1'b0, CH_NEWLINE));
		offer_char(rand_beat(1'b0, 8'hFF));
		offer_char(rand_beat(1'b1, CH_TAB));
		offer_char(rand_beat(1'b1, CH_NEWLINE));
		offer_char(rand_beat(1'b1, CH_SPACE));
		offer_char(rand_beat(1'b1, "x"));
	endtask

	// Register extremes drive the pen and the vertex coordinates into saturation.
	task automatic test_register_extremes();
		glyph_beat_t b;
		settle();
		set_registers(16'h7FFF, 16'h8000, 16'h00FF, 16'h00FF);
		b = rand_beat(1'b1, "M");
		b.w = 8'd255; b.h = 8'd255; b.d = 8'sd127;
		offer_char(b);
		offer_char(rand_beat(1'b0, CH_NEWLINE));
		offer_char(rand_beat(1'b0, CH_TAB));
		offer_char(rand_beat(1'b0, "q"));
		settle();
		set_registers(16'h8000, 16'h7FFF, 16'hFF00, 16'hAB00);
		b = rand_beat(1'b1, "g");
		b.d = -8'sd128;
		offer_char(b);
		// Zero tab spacing leaves the pen in place.
		offer_char(rand_beat(1'b0, CH_TAB));
		offer_char(rand_beat(1'b0, CH_NEWLINE));
		offer_char(rand_beat(1'b0, "k"));
	endtask

	// Tab stops, including a pen left of a moved origin, which an origin write does not move.
	task automatic test_tab_stops();
		glyph_beat_t b;
		settle();
		set_registers(16'h0000, 16'h0000, 16'h0010, 16'h0001);
		b = rand_beat(1'b1, CH_SPACE);
		b.adv = 8'd3;
		offer_char(b);
		offer_char(rand_beat(1'b0, CH_TAB));
		b.start = 1'b0;
		offer_char(b);
		settle();
		set_registers(16'd200, cfg_oy, {8'h00, cfg_lh}, {8'h00, cfg_sa});
		offer_char(rand_beat(1'b0, CH_TAB));
		offer_char(rand_beat(1'b0, "t"));
		offer_char(rand_beat(1'b1, "u"));
	endtask

	// The receiver holds off for a long stretch while glyphs keep coming.
	task automatic test_backpressure();
		settle();
		set_registers(16'd10, 16'd500, 16'h0010, 16'h0008);
		in_idle_on = 1'b0;
		hold_left = 400;
		offer_char(rand_beat(1'b1, "B"));
		for (int n = 0; n < 15; n++)
			offer_char(rand_beat(1'b0, 8'($urandom_range(33, 126))));
		in_idle_on = 1'b1;
	endtask

	// Random text in several register phases, mostly well-formed with some noise.
	task automatic test_random_text();
		glyph_beat_t b;
		for (int ph = 0; ph < 4; ph++) begin
			settle();
			set_registers(pick_origin(), pick_origin(), pick_byte_reg(), pick_byte_reg());
			in_idle_on = (ph != 2);
			out_idle_on = (ph == 0) || (ph == 3);
			for (int n = 0; n < 32; n++) begin
				if ($urandom_range(0, 99) < 85)
					b = text_beat();
				else
					b = noise_beat();
				if (n == 0)
					b.start = 1'b1;
				offer_char(b);
			end
		end
		in_idle_on = 1'b1;
		out_idle_on = 1'b1;
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_ORIGIN_X;
		cfg_wdata     = 16'h0000;
		in_valid      = 1'b0;
		start_text    = 1'b0;
		char_code     = 8'h00;
		glyph_width   = 8'h00;
		glyph_height  = 8'h00;
		glyph_descent = 8'sh00;
		glyph_advance = 8'h00;
		uv_left       = 16'h0000;
		uv_right      = 16'h0000;
		uv_top        = 16'h0000;
		uv_bottom     = 16'h0000;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_register_extremes();
		test_tab_stops();
		test_backpressure();
		test_random_text();

		settle();
		if (pending_vertices.size() != 0)
			note_mismatch($sformatf("%0d expected vertices never arrived",
				pending_vertices.size()));
		$display("Run covered %0d glyphs, %0d spaces, %0d tabs and %0d newlines; %0d vertices checked.",
			glyphs_sent, spaces_sent, tabs_sent, newlines_sent, vertices_seen);
		$display("Register phases: %0d, with a long receiver stall and saturated coordinates.",
			reg_phases);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
